FILE: rtl/core/bcdtc_pkg.sv
// shared types, constants and the segment lookup for the bcd tally counter controller
`default_nettype none

package bcdtc_pkg;

  // default digit count of the bcd counter
  localparam int NUM_DIGITS_DEF = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_HOLD_TIME  = 2'd0;
  localparam logic [1:0] CFG_BEEP_TIME  = 2'd1;
  localparam logic [1:0] CFG_BLANK_TIME = 2'd2;

  // configuration reset values
  localparam logic [15:0] HOLD_TIME_RST  = 16'd1000;
  localparam logic [7:0]  BEEP_TIME_RST  = 8'd15;
  localparam logic [15:0] BLANK_TIME_RST = 16'd12000;

  // lamp codes: bit1 buzzer, bit0 led
  localparam logic [1:0] LAMP_OFF  = 2'd0;
  localparam logic [1:0] LAMP_BEEP = 2'd2;
  localparam logic [1:0] LAMP_LONG = 2'd3;

  typedef struct packed {
    logic [15:0] hold_time;
    logic [7:0]  beep_time;
    logic [15:0] blank_time;
  } bcdtc_cfg_t;

  typedef struct packed {
    logic plus_held;
    logic minus_held;
    logic tick;
    logic pin_change;
  } bcdtc_event_t;

  // seven-segment pattern, bit0 is segment a, non-bcd codes blank
  function automatic logic [6:0] seg_lookup(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'b0111111;
      4'd1:    seg = 7'b0000110;
      4'd2:    seg = 7'b1011011;
      4'd3:    seg = 7'b1001111;
      4'd4:    seg = 7'b1100110;
      4'd5:    seg = 7'b1101101;
      4'd6:    seg = 7'b1111101;
      4'd7:    seg = 7'b0000111;
      4'd8:    seg = 7'b1111111;
      4'd9:    seg = 7'b1100111;
      default: seg = 7'b0000000;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bcdtc_bcd_step.sv
// saturating one-step bcd up or down counter over all digits
`default_nettype none

module bcdtc_bcd_step import bcdtc_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  wire logic                       dir_down,
  input  wire logic [NUM_DIGITS-1:0][3:0] digits_in,
  output logic      [NUM_DIGITS-1:0][3:0] digits_out
);

  logic at_limit;
  logic carry;

  always_comb begin
    at_limit = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits_in[i] != (dir_down ? 4'd0 : 4'd9)) at_limit = 1'b0;
    end

    // ripple of the carry or borrow, stops at the first digit that can move
    carry      = ~at_limit;
    digits_out = digits_in;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        if (dir_down) begin
          if (digits_in[i] > 4'd0) begin
            digits_out[i] = digits_in[i] - 4'd1;
            carry         = 1'b0;
          end else begin
            digits_out[i] = 4'd9;
          end
        end else begin
          if (digits_in[i] < 4'd9) begin
            digits_out[i] = digits_in[i] + 4'd1;
            carry         = 1'b0;
          end else begin
            digits_out[i] = 4'd0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bcdtc_core.sv
// per-event state update of the counter, timers, digit mux and result valid
`default_nettype none

module bcdtc_core import bcdtc_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF,
  parameter int PTR_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire logic                       out_stall,
  input  wire bcdtc_event_t               ev,
  input  wire bcdtc_cfg_t                 cfg,
  output logic                            out_valid_r,
  output logic      [6:0]                 seg_r,
  output logic      [PTR_W-1:0]           ptr_r,
  output logic                            off_r,
  output logic      [1:0]                 lamp_r,
  output logic      [NUM_DIGITS-1:0][3:0] digits_r,
  output logic                            sound_r
);

  logic [7:0]  beep_r, beep_nxt;
  logic [15:0] clr_hold_r, clr_hold_nxt;
  logic [15:0] tgl_hold_r, tgl_hold_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] clr_inc, tgl_inc;
  logic        clr_fire, tgl_fire;
  logic [NUM_DIGITS-1:0][3:0] digits_clr, digits_up, digits_dn, digits_nxt;
  logic [PTR_W-1:0] ptr_nxt;
  logic [PTR_W:0]   ptr_inc;
  logic [6:0]  seg_nxt;
  logic [1:0]  lamp_nxt;
  logic        sound_nxt, off_nxt, out_valid_nxt;

  // long-press detection
  assign clr_inc  = (clr_hold_r == 16'hFFFF) ? clr_hold_r : clr_hold_r + 16'd1;
  assign tgl_inc  = (tgl_hold_r == 16'hFFFF) ? tgl_hold_r : tgl_hold_r + 16'd1;
  assign clr_fire = ev.minus_held && (clr_inc > cfg.hold_time);
  assign tgl_fire = ev.plus_held && (tgl_inc > cfg.hold_time);

  assign digits_clr = clr_fire ? '0 : digits_r;
  assign ptr_inc    = {1'b0, ptr_r} + {{PTR_W{1'b0}}, 1'b1};

  bcdtc_bcd_step #(.NUM_DIGITS(NUM_DIGITS)) u_up (
    .dir_down  (1'b0),
    .digits_in (digits_clr),
    .digits_out(digits_up)
  );

  bcdtc_bcd_step #(.NUM_DIGITS(NUM_DIGITS)) u_dn (
    .dir_down  (1'b1),
    .digits_in (digits_clr),
    .digits_out(digits_dn)
  );

  always_comb begin
    beep_nxt     = beep_r;
    lamp_nxt     = lamp_r;
    sound_nxt    = sound_r;
    digits_nxt   = digits_clr;
    ptr_nxt      = ptr_r;
    seg_nxt      = seg_r;
    idle_nxt     = idle_r;
    clr_hold_nxt = ev.minus_held ? (clr_fire ? 16'd1 : clr_inc) : 16'd0;
    tgl_hold_nxt = ev.plus_held ? (tgl_fire ? 16'd1 : tgl_inc) : 16'd0;

    if (clr_fire || tgl_fire) begin
      beep_nxt = 8'd1;
      lamp_nxt = LAMP_LONG;
    end
    if (tgl_fire) sound_nxt = ~sound_r;

    if (ev.tick) begin
      if (beep_nxt != 8'd0 && beep_nxt != 8'hFF) beep_nxt = beep_nxt + 8'd1;
      if (beep_nxt > cfg.beep_time) begin
        beep_nxt = 8'd0;
        lamp_nxt = LAMP_OFF;
      end
      if (ptr_inc >= (PTR_W+1)'(NUM_DIGITS)) ptr_nxt = '0;
      else                                   ptr_nxt = ptr_inc[PTR_W-1:0];
      seg_nxt = seg_lookup(digits_clr[ptr_nxt]);
    end

    if (ev.pin_change) begin
      idle_nxt = 16'd0;
      if (ev.plus_held && beep_nxt == 8'd0) begin
        digits_nxt = digits_up;
        if (sound_nxt) lamp_nxt = LAMP_BEEP;
        beep_nxt = 8'd1;
      end
      if (ev.minus_held && beep_nxt == 8'd0) begin
        digits_nxt = digits_dn;
        if (sound_nxt) lamp_nxt = LAMP_BEEP;
        beep_nxt = 8'd1;
      end
    end

    if (idle_nxt != 16'hFFFF) idle_nxt = idle_nxt + 16'd1;
    off_nxt = idle_nxt > cfg.blank_time;

    out_valid_nxt = fire ? 1'b1 : (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beep_r      <= 8'd0;
      clr_hold_r  <= 16'd0;
      tgl_hold_r  <= 16'd0;
      idle_r      <= 16'd0;
      digits_r    <= '0;
      ptr_r       <= '0;
      seg_r       <= 7'd0;
      lamp_r      <= LAMP_OFF;
      sound_r     <= 1'b1;
      off_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        beep_r     <= beep_nxt;
        clr_hold_r <= clr_hold_nxt;
        tgl_hold_r <= tgl_hold_nxt;
        idle_r     <= idle_nxt;
        digits_r   <= digits_nxt;
        ptr_r      <= ptr_nxt;
        seg_r      <= seg_nxt;
        lamp_r     <= lamp_nxt;
        sound_r    <= sound_nxt;
        off_r      <= off_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bcd_tally_counter_controller_unit.sv
// top level of the bcd tally counter controller with seven-segment digit mux
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  plus_held, minus_held, tick, pin_change
// out_      output     out_valid / out_stall segments, digit_index, display_off, lamp,
//                                           count_bcd, sound_on
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one transaction in, one transaction out; a new event can be taken every cycle unless out_stall holds the result
// an event passes the event register, then the state registers that form the result
// the result registers are the controller state itself, so the state only moves when
// the result slot is free or being taken
// rst_n is synchronous, active low; it clears the count, timers and registers and
// restores the configuration defaults
// a stalled output holds its result while one further event waits in the input register

module bcd_tally_counter_controller_unit import bcdtc_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // event channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_plus_held,
  input  wire logic        in_minus_held,
  input  wire logic        in_tick,
  input  wire logic        in_pin_change,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [6:0]  out_segments,
  output logic      [1:0]  out_digit_index,
  output logic             out_display_off,
  output logic      [1:0]  out_lamp,
  output logic      [15:0] out_count_bcd,
  output logic             out_sound_on,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int PTR_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // configuration registers
  bcdtc_cfg_t cfg_r;

  // input event register
  logic         ev_valid_r, ev_valid_nxt;
  bcdtc_event_t ev_r;
  logic         in_take;
  logic         advance;
  logic         fire;

  // result side
  logic                       out_valid_r;
  logic [6:0]                 seg_r;
  logic [PTR_W-1:0]           ptr_r;
  logic                       off_r;
  logic [1:0]                 lamp_r;
  logic [NUM_DIGITS-1:0][3:0] digits_r;
  logic                       sound_r;
  logic [PTR_W+1:0]           ptr_ext;
  logic [(NUM_DIGITS+4)*4-1:0] digits_ext;

  // configuration is always writable; writes outside the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time  <= HOLD_TIME_RST;
      cfg_r.beep_time  <= BEEP_TIME_RST;
      cfg_r.blank_time <= BLANK_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOLD_TIME:  cfg_r.hold_time  <= cfg_data;
        CFG_BEEP_TIME:  cfg_r.beep_time  <= cfg_data[7:0];
        CFG_BLANK_TIME: cfg_r.blank_time <= cfg_data;
        default:        ;
      endcase
    end
  end

  // result slot can take a new result when empty or being drained this cycle
  assign advance  = ~out_valid_r | ~out_stall;
  assign fire     = ev_valid_r & advance;
  // the input register frees up whenever its event moves into the state stage
  assign in_stall = ev_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    if (in_take)      ev_valid_nxt = 1'b1;
    else if (advance) ev_valid_nxt = 1'b0;
    else              ev_valid_nxt = ev_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= ev_valid_nxt;
    end
  end

  // event payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_r.plus_held  <= in_plus_held;
      ev_r.minus_held <= in_minus_held;
      ev_r.tick       <= in_tick;
      ev_r.pin_change <= in_pin_change;
    end
  end

  bcdtc_core #(
    .NUM_DIGITS(NUM_DIGITS),
    .PTR_W     (PTR_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .out_stall  (out_stall),
    .ev         (ev_r),
    .cfg        (cfg_r),
    .out_valid_r(out_valid_r),
    .seg_r      (seg_r),
    .ptr_r      (ptr_r),
    .off_r      (off_r),
    .lamp_r     (lamp_r),
    .digits_r   (digits_r),
    .sound_r    (sound_r)
  );

  // only the low four digits and the low two pointer bits reach the ports
  assign ptr_ext    = {2'b00, ptr_r};
  assign digits_ext = {16'h0000, digits_r};

  assign out_valid       = out_valid_r;
  assign out_segments    = seg_r;
  assign out_digit_index = ptr_ext[1:0];
  assign out_display_off = off_r;
  assign out_lamp        = lamp_r;
  assign out_count_bcd   = digits_ext[15:0];
  assign out_sound_on    = sound_r;

endmodule

`default_nettype wire
